// ===== rtl/qa_pkg.sv =====
// ----------------------------------------------------------------------------
// qa_pkg
// Shared constants and command codes for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qa_pkg;

  // default component format, Q3.12
  localparam int QA_CW = 16;
  localparam int QA_FB = 12;

  // command codes
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_CONJ     = 4'd4,
    CMD_INV      = 4'd5,
    CMD_NORM     = 4'd6,
    CMD_NORMVEC  = 4'd7,
    CMD_MAG      = 4'd8,
    CMD_MAGSQ    = 4'd9,
    CMD_VECMAG   = 4'd10,
    CMD_VECMAGSQ = 4'd11
  } cmd_t;

endpackage

// ===== rtl/qa_chan_if.sv =====
// ----------------------------------------------------------------------------
// qa_chan_if
// Valid/ready channels for operand transfers and result transfers.
// ----------------------------------------------------------------------------

// operand channel
interface qa_in_if import qa_pkg::*; #(
  parameter int CW = QA_CW
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           command;
  logic signed [CW-1:0] a_w;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_w;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;

  modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

// result channel
interface qa_out_if import qa_pkg::*; #(
  parameter int CW = QA_CW
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] r_w;
  logic signed [CW-1:0] r_x;
  logic signed [CW-1:0] r_y;
  logic signed [CW-1:0] r_z;
  logic                 overflow;
  logic                 divide_by_zero;
  logic                 equal;

  modport source (output valid, r_w, r_x, r_y, r_z, overflow, divide_by_zero, equal,
                  input ready);
  modport sink (input valid, r_w, r_x, r_y, r_z, overflow, divide_by_zero, equal,
                output ready);
endinterface

// ===== rtl/qa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qa_sqrt_cell
// One root bit of a pipelined restoring square root; two radicand bits a cell.
// ----------------------------------------------------------------------------
module qa_sqrt_cell import qa_pkg::*; #(
  parameter int ROOT_W = QA_CW + 1,
  parameter int RAD_W  = 2 * (QA_CW + 1)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [ROOT_W+2:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W+2:0] rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [RAD_W-1:0]  rad_o
);
  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;
  logic [REM_W-1:0]  rem_nxt, rem_r;
  logic [ROOT_W-1:0] root_nxt, root_r;
  logic [RAD_W-1:0]  rad_nxt, rad_r;

  // trial subtract of 4*root+1
  always_comb begin
    rem_sh   = {rem_i[REM_W-3:0], rad_i[RAD_W-1:RAD_W-2]};
    trial    = {1'b0, root_i, 2'b01};
    fits     = (rem_sh >= trial);
    rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_i[ROOT_W-2:0], fits};
    rad_nxt  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
endmodule

// ===== rtl/qa_div_cell.sv =====
// ----------------------------------------------------------------------------
// qa_div_cell
// One quotient bit of a pipelined restoring divider.
// ----------------------------------------------------------------------------
module qa_div_cell import qa_pkg::*; #(
  parameter int DIV_W = 2 * QA_CW + 1,
  parameter int QUO_W = QA_CW
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] dvs_i,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [QUO_W-1:0] nq_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [QUO_W-1:0] nq_o
);
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   diff;
  logic             fits;
  logic [DIV_W-1:0] rem_nxt, rem_r;
  logic [QUO_W-1:0] nq_nxt, nq_r;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_i, nq_i[QUO_W-1]};
    diff    = rem_sh - {1'b0, dvs_i};
    fits    = (rem_sh >= {1'b0, dvs_i});
    rem_nxt = fits ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    nq_nxt  = {nq_i[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign rem_o = rem_r;
  assign nq_o  = nq_r;
endmodule

// ===== rtl/quaternion_alu_core.sv =====
// Throughput: one operand transfer per cycle while the skid stage is empty;
// set by the root cell chain and the four divider cell chains, each cell one
// bit a cycle.
// Reset clears the stage valid bits and the output and skid valid bits.
// ----------------------------------------------------------------------------
// quaternion_alu_core
// Pipelined fixed-point quaternion ALU: add, sub, product, divide, conjugate,
// inverse, normalize and magnitudes with saturation and status flags.
// ----------------------------------------------------------------------------
module quaternion_alu_core import qa_pkg::*; #(
  parameter int COMPONENT_WIDTH = QA_CW,
  parameter int FRACTION_BITS   = QA_FB
) (
  input logic   clk,
  input logic   rst_n,
  qa_in_if.sink    in_chan,
  qa_out_if.source out_chan
);
  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int SW   = 2 * W + 1;
  localparam int RTW  = W + 1;
  localparam int RDW  = 2 * RTW;
  localparam int REMW = RTW + 3;
  localparam int DW   = SW;
  localparam int QW   = W;
  localparam int NW   = W + 2 * F;
  localparam int CPW  = (NW > DW) ? NW : DW;
  localparam int PW   = 2 * W;
  localparam int HW   = 2 * W + 2;

  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    cmd_t                cmd;
    logic [3:0][W-1:0]   a;
    logic [3:0][W-1:0]   b;
    logic                eq;
    logic [SW-1:0]       rad;
    logic [SW-1:0]       sb;
    logic [RTW-1:0]      root;
    logic                dz;
    logic [DW-1:0]       dvs;
    logic [3:0]          big;
    logic [3:0]          neg;
    logic [3:0][W-1:0]   q;
    logic                ovf_d;
  } pay_t;

  typedef struct packed {
    logic [W-1:0] w;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] z;
    logic         ovf;
    logic         dz;
    logic         eq;
  } res_t;

  // saturate a W+1 bit signed value
  function automatic logic [W:0] sat_n(input logic [W:0] s);
    if (s[W] != s[W-1]) return {1'b1, (s[W] ? CMIN : CMAX)};
    return {1'b0, s[W-1:0]};
  endfunction

  // saturate a product sum
  function automatic logic [W:0] sat_h(input logic signed [HW-1:0] s);
    if (s > $signed({{(HW-W){1'b0}}, CMAX})) return {1'b1, CMAX};
    if (s < $signed({{(HW-W){1'b1}}, CMIN})) return {1'b1, CMIN};
    return {1'b0, s[W-1:0]};
  endfunction

  // saturate an unsigned magnitude
  function automatic logic [W:0] usat(input logic [SW-1:0] u);
    if (u > {{(SW-W){1'b0}}, CMAX}) return {1'b1, CMAX};
    return {1'b0, u[W-1:0]};
  endfunction

  // floor a product to F fraction bits, sign extended for summing
  function automatic logic signed [HW-1:0] fl(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p >>> F;
    return {{2{t[PW-1]}}, t};
  endfunction

  // global advance: the whole pipe moves while the skid stage is empty
  logic en;
  logic skv_r, ov_r;
  res_t out_pay_r, skid_pay_r, res;

  assign en            = !skv_r;
  assign in_chan.ready = en;

  // stage valid bits
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [RTW-1:0] sv_r;
  logic [QW-1:0]  dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      sv_r <= '0;
      v3_r <= 1'b0;
      dv_r <= '0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_chan.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      sv_r <= {sv_r[RTW-2:0], v2_r};
      v3_r <= sv_r[RTW-1];
      dv_r <= {dv_r[QW-2:0], v3_r};
      v4_r <= dv_r[QW-1];
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // operand capture
  pay_t p0_r, p0_nxt;

  always_comb begin
    p0_nxt     = '0;
    p0_nxt.cmd = cmd_t'(in_chan.command);
    p0_nxt.a   = {in_chan.a_z, in_chan.a_y, in_chan.a_x, in_chan.a_w};
    p0_nxt.b   = {in_chan.b_z, in_chan.b_y, in_chan.b_x, in_chan.b_w};
    p0_nxt.eq  = (in_chan.a_w == in_chan.b_w) && (in_chan.a_x == in_chan.b_x) &&
                 (in_chan.a_y == in_chan.b_y) && (in_chan.a_z == in_chan.b_z);
  end

  always_ff @(posedge clk) begin
    if (en) p0_r <= p0_nxt;
  end

  // component squares
  pay_t p1_r;
  logic signed [PW-1:0] sqa_r [4];
  logic signed [PW-1:0] sqb_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p0_r;
      for (int i = 0; i < 4; i++) begin
        sqa_r[i] <= $signed(p0_r.a[i]) * $signed(p0_r.a[i]);
        sqb_r[i] <= $signed(p0_r.b[i]) * $signed(p0_r.b[i]);
      end
    end
  end

  // sums of squares, radicand select
  pay_t p2_r, p2_nxt;
  logic [SW-1:0] sa_vec, sa_all, sb_all;

  always_comb begin
    sa_vec = {1'b0, sqa_r[1]} + {1'b0, sqa_r[2]} + {1'b0, sqa_r[3]};
    sa_all = sa_vec + {1'b0, sqa_r[0]};
    sb_all = {1'b0, sqb_r[0]} + {1'b0, sqb_r[1]} + {1'b0, sqb_r[2]} + {1'b0, sqb_r[3]};
    p2_nxt = p1_r;
    p2_nxt.rad = (p1_r.cmd inside {CMD_NORMVEC, CMD_VECMAG, CMD_VECMAGSQ}) ? sa_vec : sa_all;
    p2_nxt.sb  = sb_all;
  end

  always_ff @(posedge clk) begin
    if (en) p2_r <= p2_nxt;
  end

  // square root cell chain
  logic [REMW-1:0] rem_w  [RTW+1];
  logic [RTW-1:0]  root_w [RTW+1];
  logic [RDW-1:0]  rad_w  [RTW+1];
  pay_t            sp_r   [RTW];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = {1'b0, p2_r.rad};

  for (genvar j = 0; j < RTW; j++) begin : g_sqrt
    qa_sqrt_cell #(
      .ROOT_W (RTW),
      .RAD_W  (RDW)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .rad_i  (rad_w[j]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1]),
      .rad_o  (rad_w[j+1])
    );

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) sp_r[j] <= p2_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) sp_r[j] <= sp_r[j-1];
      end
    end
  end

  // divider setup: divisor, sign and scaled magnitude per lane
  pay_t p3_r, p3_nxt;
  logic [DW-1:0] rem0_r [4], rem0_nxt [4];
  logic [QW-1:0] nq0_r  [4], nq0_nxt  [4];

  always_comb begin
    logic [3:0][W-1:0] src;
    logic              flip;
    logic              long_sh;
    logic [W-1:0]      mag;
    logic [CPW-1:0]    nfull;
    logic [CPW-1:0]    hi;

    p3_nxt      = sp_r[RTW-1];
    p3_nxt.root = root_w[RTW];
    src         = sp_r[RTW-1].a;
    flip        = 1'b0;
    long_sh     = 1'b0;
    case (sp_r[RTW-1].cmd)
      CMD_INV: begin
        p3_nxt.dvs = sp_r[RTW-1].rad;
        flip       = 1'b1;
        long_sh    = 1'b1;
      end
      CMD_DIV: begin
        p3_nxt.dvs = sp_r[RTW-1].sb;
        src        = sp_r[RTW-1].b;
        flip       = 1'b1;
        long_sh    = 1'b1;
      end
      CMD_NORM, CMD_NORMVEC: begin
        p3_nxt.dvs = {{(DW-RTW){1'b0}}, root_w[RTW]};
      end
      default: begin
        p3_nxt.dvs = sp_r[RTW-1].rad;
      end
    endcase
    p3_nxt.dz = (sp_r[RTW-1].cmd inside {CMD_DIV, CMD_INV, CMD_NORM, CMD_NORMVEC}) &&
                (p3_nxt.dvs == '0);

    for (int l = 0; l < 4; l++) begin
      mag   = src[l][W-1] ? (~src[l] + 1'b1) : src[l];
      nfull = CPW'(mag) << (long_sh ? 2 * F : F);
      hi    = nfull >> QW;
      p3_nxt.neg[l] = src[l][W-1] ^ (flip && (l != 0));
      p3_nxt.big[l] = (hi >= CPW'(p3_nxt.dvs));
      rem0_nxt[l]   = hi[DW-1:0];
      nq0_nxt[l]    = nfull[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_r <= p3_nxt;
      for (int l = 0; l < 4; l++) begin
        rem0_r[l] <= rem0_nxt[l];
        nq0_r[l]  <= nq0_nxt[l];
      end
    end
  end

  // divider cell chains, one per lane
  logic [DW-1:0] drem_w [4][QW+1];
  logic [QW-1:0] dnq_w  [4][QW+1];
  pay_t          dp_r   [QW];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign drem_w[l][0] = rem0_r[l];
    assign dnq_w[l][0]  = nq0_r[l];

    for (genvar k = 0; k < QW; k++) begin : g_bit
      qa_div_cell #(
        .DIV_W (DW),
        .QUO_W (QW)
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .dvs_i ((k == 0) ? p3_r.dvs : dp_r[(k == 0) ? 0 : k-1].dvs),
        .rem_i (drem_w[l][k]),
        .nq_i  (dnq_w[l][k]),
        .rem_o (drem_w[l][k+1]),
        .nq_o  (dnq_w[l][k+1])
      );
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_dpay
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) dp_r[k] <= p3_r;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) dp_r[k] <= dp_r[k-1];
      end
    end
  end

  // signed quotients with saturation
  pay_t p4_r, p4_nxt;

  always_comb begin
    logic [W-1:0] qv;
    logic         ov;

    p4_nxt       = dp_r[QW-1];
    p4_nxt.ovf_d = 1'b0;
    for (int l = 0; l < 4; l++) begin
      qv = dnq_w[l][QW];
      if (dp_r[QW-1].neg[l]) begin
        ov = dp_r[QW-1].big[l] || (qv > CMIN);
        p4_nxt.q[l] = ov ? CMIN : (~qv + 1'b1);
      end else begin
        ov = dp_r[QW-1].big[l] || (qv > CMAX);
        p4_nxt.q[l] = ov ? CMAX : qv;
      end
      if (!(l == 0 && dp_r[QW-1].cmd == CMD_NORMVEC)) p4_nxt.ovf_d = p4_nxt.ovf_d | ov;
    end
  end

  always_ff @(posedge clk) begin
    if (en) p4_r <= p4_nxt;
  end

  // hamilton partial products
  pay_t p5_r;
  logic signed [PW-1:0] prod_r [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      p5_r <= p4_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_r[i][j] <= $signed(p4_r.a[i]) *
                          $signed((p4_r.cmd == CMD_DIV) ? p4_r.q[j] : p4_r.b[j]);
        end
      end
    end
  end

  // floored terms summed per component
  pay_t p6_r;
  logic signed [HW-1:0] hsum_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      p6_r      <= p5_r;
      hsum_r[0] <= fl(prod_r[0][0]) - fl(prod_r[1][1]) - fl(prod_r[2][2]) - fl(prod_r[3][3]);
      hsum_r[1] <= fl(prod_r[0][1]) + fl(prod_r[1][0]) + fl(prod_r[2][3]) - fl(prod_r[3][2]);
      hsum_r[2] <= fl(prod_r[0][2]) - fl(prod_r[1][3]) + fl(prod_r[2][0]) + fl(prod_r[3][1]);
      hsum_r[3] <= fl(prod_r[0][3]) + fl(prod_r[1][2]) - fl(prod_r[2][1]) + fl(prod_r[3][0]);
    end
  end

  // result select
  always_comb begin
    logic [W-1:0] rv [4];
    logic         ov;
    logic [W:0]   t;

    ov = 1'b0;
    t  = '0;
    for (int i = 0; i < 4; i++) rv[i] = '0;
    case (p6_r.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          t = sat_n({p6_r.a[i][W-1], p6_r.a[i]} + {p6_r.b[i][W-1], p6_r.b[i]});
          rv[i] = t[W-1:0];
          ov    = ov | t[W];
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 4; i++) begin
          t = sat_n({p6_r.a[i][W-1], p6_r.a[i]} - {p6_r.b[i][W-1], p6_r.b[i]});
          rv[i] = t[W-1:0];
          ov    = ov | t[W];
        end
      end
      CMD_MUL, CMD_DIV: begin
        for (int i = 0; i < 4; i++) begin
          t = sat_h(hsum_r[i]);
          rv[i] = t[W-1:0];
          ov    = ov | t[W];
        end
        if (p6_r.cmd == CMD_DIV) ov = ov | p6_r.ovf_d;
      end
      CMD_CONJ: begin
        rv[0] = p6_r.a[0];
        for (int i = 1; i < 4; i++) begin
          t = sat_n({(W+1){1'b0}} - {p6_r.a[i][W-1], p6_r.a[i]});
          rv[i] = t[W-1:0];
          ov    = ov | t[W];
        end
      end
      CMD_INV, CMD_NORM: begin
        for (int i = 0; i < 4; i++) rv[i] = p6_r.q[i];
        ov = p6_r.ovf_d;
      end
      CMD_NORMVEC: begin
        rv[0] = p6_r.a[0];
        for (int i = 1; i < 4; i++) rv[i] = p6_r.q[i];
        ov = p6_r.ovf_d;
      end
      CMD_MAG, CMD_VECMAG: begin
        t     = usat({{(SW-RTW){1'b0}}, p6_r.root});
        rv[0] = t[W-1:0];
        ov    = t[W];
      end
      CMD_MAGSQ, CMD_VECMAGSQ: begin
        t     = usat(p6_r.rad >> F);
        rv[0] = t[W-1:0];
        ov    = t[W];
      end
      default: begin
        ov = 1'b0;
      end
    endcase

    // zero divisor forces a zero result
    if (p6_r.dz) begin
      for (int i = 0; i < 4; i++) rv[i] = '0;
      ov = 1'b0;
    end

    res.w   = rv[0];
    res.x   = rv[1];
    res.y   = rv[2];
    res.z   = rv[3];
    res.ovf = ov;
    res.dz  = p6_r.dz;
    res.eq  = p6_r.eq;
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      skv_r <= 1'b0;
    end else if (skv_r) begin
      if (out_chan.ready) skv_r <= 1'b0;
    end else if (v6_r) begin
      if (!ov_r || out_chan.ready) ov_r <= 1'b1;
      else                         skv_r <= 1'b1;
    end else if (out_chan.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skv_r) begin
      if (out_chan.ready) out_pay_r <= skid_pay_r;
    end else if (v6_r) begin
      if (!ov_r || out_chan.ready) out_pay_r  <= res;
      else                         skid_pay_r <= res;
    end
  end

  assign out_chan.valid          = ov_r;
  assign out_chan.r_w            = out_pay_r.w;
  assign out_chan.r_x            = out_pay_r.x;
  assign out_chan.r_y            = out_pay_r.y;
  assign out_chan.r_z            = out_pay_r.z;
  assign out_chan.overflow       = out_pay_r.ovf;
  assign out_chan.divide_by_zero = out_pay_r.dz;
  assign out_chan.equal          = out_pay_r.eq;
endmodule
